FILE: design/consistent_hash_ring_select_unit_macros.svh
// assertion macros for the hash ring select unit
`ifndef CONSISTENT_HASH_RING_SELECT_UNIT_MACROS_SVH
`define CONSISTENT_HASH_RING_SELECT_UNIT_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define CHR_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// check that a condition implies a consequence in the next cycle
`define CHR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/chrs_pkg.sv
// ----------------------------------------------------------------------------
// chrs_pkg
// types and constants shared by the hash ring select unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chrs_pkg;

    localparam int RING_DEPTH   = 1024;
    localparam int SERVER_COUNT = 16;
    localparam int IDX_W        = $clog2(RING_DEPTH);
    localparam int CNT_W        = $clog2(RING_DEPTH + 1);

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DOWN  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key_hash;
        logic [3:0]  server_num;
        logic [15:0] excluded_mask;
        logic [15:0] available_mask;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen_server;
        logic [10:0] points_changed;
        logic [10:0] points_held;
    } t_out_item;

endpackage

FILE: design/consistent_hash_ring_select_unit.sv
// ----------------------------------------------------------------------------
// consistent_hash_ring_select_unit
// sorted ring of hashed points with insert, remove and walk-forward lookup
// ----------------------------------------------------------------------------
//  channel | signals                      | direction
//  input   | i_valid, o_stall, i_data     | in
//  output  | o_valid, i_stall, o_data     | out
//
//  one transaction is worked at a time; the ring lives in one memory with
//  a registered read port, so each search or walk step issues a read and then uses it
//  lookup: binary search, a read at the lower bound, then a walk forward step by step
//  insert: same search, shift of the entries above it, then the write; remove: one pass
//  reset clears state, point count, result flag and remove flag; stores need no clearing
//  the result waits in the output register and blocks input until taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "consistent_hash_ring_select_unit_macros.svh"

module consistent_hash_ring_select_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  chrs_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output chrs_pkg::t_out_item o_data
);

    localparam int IW = chrs_pkg::IDX_W;
    localparam int CW = chrs_pkg::CNT_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SRCH   = 9'b000000010,
        S_SRCHW  = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_WALK   = 9'b000010000,
        S_WALKW  = 9'b000100000,
        S_SHIFT  = 9'b001000000,
        S_SHIFTW = 9'b010000000,
        S_REM    = 9'b100000000
    } t_state;

    // ring memory, hash and owner packed in one word
    logic [35:0] r_mem [chrs_pkg::RING_DEPTH];
    logic [35:0] r_rd;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [35:0]   wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    t_state r_state, n_state;
    chrs_pkg::t_in_item r_req, n_req;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0] r_idx, n_idx;      // walk index, shift index, remove read
    logic [CW-1:0] r_cnt, n_cnt;      // walk count, remove write index
    logic          r_pend, n_pend;    // remove: read issued last step
    logic          r_ov, n_ov;
    chrs_pkg::t_out_item r_out, n_out;

    logic [CW-1:0] mid;
    logic [31:0]   rd_hash;
    logic [3:0]    rd_srv;
    logic          rd_below;
    logic [3:0]    srch_srv;

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign rd_hash  = r_rd[35:4];
    assign rd_srv   = r_rd[3:0];
    assign srch_srv = (r_req.cmd == chrs_pkg::CMD_INSERT) ? r_req.server_num : 4'd0;
    assign rd_below = (rd_hash != r_req.key_hash) ? (rd_hash < r_req.key_hash)
                                                  : (rd_srv < srch_srv);

    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        logic          last;
        logic [CW-1:0] nxt;
        n_state = r_state;
        n_req   = r_req;
        n_total = r_total;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_ov    = r_ov;
        n_out   = r_out;
        rd_addr = mid[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = r_rd;
        last    = 1'b0;
        nxt     = '0;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_req = i_data;
                    n_lo  = '0;
                    n_hi  = r_total;
                    n_out = '0;
                    n_idx = '0;
                    n_cnt = '0;
                    n_pend = 1'b0;
                    priority if (i_data.cmd == chrs_pkg::CMD_LOOKUP) begin
                        if (r_total == '0) begin
                            n_out.status = chrs_pkg::ST_EMPTY;
                            n_ov = 1'b1;
                        end else begin
                            n_state = S_SRCH;
                        end
                    end else if (i_data.cmd == chrs_pkg::CMD_INSERT) begin
                        if ({1'b0, i_data.server_num} >= 5'(chrs_pkg::SERVER_COUNT)) begin
                            n_out.points_held = 11'(r_total);
                            n_ov = 1'b1;
                        end else begin
                            n_state = S_SRCH;
                        end
                    end else if (i_data.cmd == chrs_pkg::CMD_REMOVE) begin
                        n_state = S_REM;
                    end else begin
                        n_out.points_held = 11'(r_total);
                        n_ov = 1'b1;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    rd_addr = mid[IW-1:0];
                    n_state = S_SRCHW;
                end else begin
                    rd_addr = r_lo[IW-1:0];
                    n_state = S_DECIDE;
                end
            end
            S_SRCHW: begin
                if (rd_below) n_lo = mid + 1'b1;
                else          n_hi = mid;
                n_state = S_SRCH;
            end
            S_DECIDE: begin
                // r_rd holds the entry at the lower bound
                if (r_req.cmd == chrs_pkg::CMD_INSERT) begin
                    if (r_lo < r_total && rd_hash == r_req.key_hash
                        && rd_srv == r_req.server_num) begin
                        n_out.points_held = 11'(r_total);
                        n_ov = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_total >= CW'(chrs_pkg::RING_DEPTH)) begin
                        n_out.status = chrs_pkg::ST_FULL;
                        n_out.points_held = 11'(r_total);
                        n_ov = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_total;
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_idx = (r_lo >= r_total) ? '0 : r_lo;
                    n_cnt = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                rd_addr = r_idx[IW-1:0];
                n_state = S_WALKW;
            end
            S_WALKW: begin
                last = (r_cnt + 1'b1) == r_total;
                if ((last || !r_req.excluded_mask[rd_srv]) && r_req.available_mask[rd_srv])
                begin
                    n_out.chosen_server = rd_srv;
                    n_out.points_held = 11'(r_total);
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end else if (last) begin
                    n_out.status = chrs_pkg::ST_DOWN;
                    n_out.points_held = 11'(r_total);
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    nxt = r_idx + 1'b1;
                    n_idx = (nxt >= r_total) ? '0 : nxt;
                    n_cnt = r_cnt + 1'b1;
                    n_state = S_WALK;
                end
            end
            S_SHIFT: begin
                if (r_idx > r_lo) begin
                    nxt = r_idx - 1'b1;
                    rd_addr = nxt[IW-1:0];
                    n_state = S_SHIFTW;
                end else begin
                    wr_en = 1'b1;
                    wr_addr = r_lo[IW-1:0];
                    wr_data = {r_req.key_hash, r_req.server_num};
                    n_total = r_total + 1'b1;
                    n_out.points_changed = 11'd1;
                    n_out.points_held = 11'(r_total + 1'b1);
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SHIFTW: begin
                wr_en = 1'b1;
                wr_addr = r_idx[IW-1:0];
                wr_data = r_rd;
                n_idx = r_idx - 1'b1;
                n_state = S_SHIFT;
            end
            S_REM: begin
                // read at r_idx issued this cycle, data of previous read arrives
                rd_addr = r_idx[IW-1:0];
                if (r_pend && rd_srv != r_req.server_num) begin
                    wr_en = 1'b1;
                    wr_addr = r_cnt[IW-1:0];
                    wr_data = r_rd;
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_idx < r_total) begin
                    n_idx = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    nxt = (r_pend && rd_srv != r_req.server_num) ? r_cnt + 1'b1 : r_cnt;
                    n_total = nxt;
                    n_out.points_changed = 11'(r_total - nxt);
                    n_out.points_held = 11'(nxt);
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_ov    <= n_ov;
            r_pend  <= n_pend;
        end
        r_req <= n_req;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    // point count never exceeds ring depth
    `CHR_ASSERT_IMPL(a_total_range, i_clk, i_rst_n, 1'b1,
        r_total <= CW'(chrs_pkg::RING_DEPTH), "point count beyond ring depth")
    // a busy engine never holds a pending result
    `CHR_ASSERT_IMPL(a_busy_no_result, i_clk, i_rst_n, r_state != S_IDLE, !r_ov,
        "result pending while engine busy")
    // a held result stays while stalled
    `CHR_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_data), "stalled result changed")

endmodule
